>>> src/lcf_pkg.sv
package lcf_pkg;

	// Default widths and fixed field widths
	localparam int PIXEL_BITS_DEF = 12;
	localparam int TIMER_BITS_DEF = 16;
	localparam int CHG_MS_BITS    = 16;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int FUNC_BITS      = 2;
	localparam int SIDE_BITS      = 2;
	localparam int OUT_DATA_BITS  = 8;

	// Hold times in milliseconds
	localparam int INIT_HOLD_MS = 500;
	localparam int DONE_HOLD_MS = 1000;

	// Register reset values
	localparam int MIN_LANE_WIDTH_RST = 200;
	localparam int SAFE_MARGIN_RST    = 50;
	localparam int MAX_CHANGE_MS_RST  = 5000;
	localparam int KEEP_THRESHOLD_RST = 30;

	typedef enum logic [2:0] {
		MODE_KEEP   = 3'd0,
		MODE_INIT_L = 3'd1,
		MODE_CHG_L  = 3'd2,
		MODE_INIT_R = 3'd3,
		MODE_CHG_R  = 3'd4,
		MODE_DONE   = 3'd5
	} mode_t;

	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_FRAME   = 2'd0,
		FUNC_TICK    = 2'd1,
		FUNC_REQUEST = 2'd2,
		FUNC_ABORT   = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MIN_LANE_WIDTH = 2'd0,
		REG_SAFE_MARGIN    = 2'd1,
		REG_MAX_CHANGE_MS  = 2'd2,
		REG_KEEP_THRESHOLD = 2'd3
	} reg_idx_t;

	localparam logic [SIDE_BITS-1:0] SIDE_LEFT  = 2'd1;
	localparam logic [SIDE_BITS-1:0] SIDE_RIGHT = 2'd2;

endpackage

>>> src/lane_change_fsm.sv
// Lane-change sequencer with a one-word input register and a one-word result register.
// A word passes through the input register and then the result register before its result shows on m_tdata.
// Throughput: one word per cycle while m_tready holds; the state update is a single compare-and-select pass.
// Stall: while a result waits the input register takes one more word, then s_tready drops.
// Reset (arst_n low, asynchronous): mode to lane keeping, no pending request, timer zero,
// registers to min width 200, margin 50, timeout 5000 ms, threshold 30, both stages empty.
module lane_change_fsm
	import lcf_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// lanes_detected, lane_width, left_distance, right_distance, direction, zero pad
	input  logic [((3*PIXEL_BITS+3+7)/8)*8-1:0] s_tdata,
	// func
	input  logic [FUNC_BITS-1:0]     s_tuser,
	// result stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// state_code[2:0], changing, request_pending, zero pad
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	// configuration writes
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int IN_BITS = 3*PIXEL_BITS + 3;
	localparam int CMP_W   = (TIMER_BITS > CHG_MS_BITS) ? TIMER_BITS : CHG_MS_BITS;

	// Field offsets inside the input word
	localparam int OFS_W   = 1;
	localparam int OFS_L   = 1 + PIXEL_BITS;
	localparam int OFS_R   = 1 + 2*PIXEL_BITS;
	localparam int OFS_DIR = 1 + 3*PIXEL_BITS;

	// Configuration registers
	logic [PIXEL_BITS-1:0]  min_lane_width_q;
	logic [PIXEL_BITS-1:0]  safe_margin_q;
	logic [CHG_MS_BITS-1:0] max_change_ms_q;
	logic [PIXEL_BITS-1:0]  keep_threshold_q;

	// Input register
	logic               valid_s1;
	func_t              func_s1;
	logic [IN_BITS-1:0] data_s1;

	// Result register
	logic                     valid_s2;
	logic [OUT_DATA_BITS-1:0] data_s2;

	// Sequencer state
	mode_t                 mode_q, mode_d;
	logic                  pending_q, pending_d;
	logic [SIDE_BITS-1:0]  side_q, side_d;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;

	// Unpacked fields of the word in stage 1
	logic                  seen;
	logic [PIXEL_BITS-1:0] lane_w, left_d, right_d;
	logic [SIDE_BITS-1:0]  dir;

	logic                  advance;
	logic                  lane_safe, lane_centred;
	logic                  init_over, done_over, change_over;
	logic [PIXEL_BITS:0]   two_l, two_r, w_ext, lim, diff_l, diff_r;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_lane_width_q <= PIXEL_BITS'(MIN_LANE_WIDTH_RST);
			safe_margin_q    <= PIXEL_BITS'(SAFE_MARGIN_RST);
			max_change_ms_q  <= CHG_MS_BITS'(MAX_CHANGE_MS_RST);
			keep_threshold_q <= PIXEL_BITS'(KEEP_THRESHOLD_RST);
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_LANE_WIDTH: min_lane_width_q <= cfg_data[PIXEL_BITS-1:0];
				REG_SAFE_MARGIN:    safe_margin_q    <= cfg_data[PIXEL_BITS-1:0];
				REG_MAX_CHANGE_MS:  max_change_ms_q  <= cfg_data[CHG_MS_BITS-1:0];
				REG_KEEP_THRESHOLD: keep_threshold_q <= cfg_data[PIXEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 drains into the result register whenever that one is free or being taken
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= func_t'(s_tuser);
			data_s1 <= s_tdata[IN_BITS-1:0];
		end
	end

	assign seen    = data_s1[0];
	assign lane_w  = data_s1[OFS_W +: PIXEL_BITS];
	assign left_d  = data_s1[OFS_L +: PIXEL_BITS];
	assign right_d = data_s1[OFS_R +: PIXEL_BITS];
	assign dir     = data_s1[OFS_DIR +: SIDE_BITS];

	// Target side must show more than the margin; only a seen, wide enough lane qualifies
	always_comb begin
		lane_safe = 1'b0;
		if (seen && (lane_w >= min_lane_width_q)) begin
			if (side_q == SIDE_LEFT) begin
				lane_safe = left_d > safe_margin_q;
			end else if (side_q == SIDE_RIGHT) begin
				lane_safe = right_d > safe_margin_q;
			end
		end
	end

	// Centered: |2*dist - width| below 2*threshold on both sides
	assign two_l  = {left_d, 1'b0};
	assign two_r  = {right_d, 1'b0};
	assign w_ext  = {1'b0, lane_w};
	assign lim    = {keep_threshold_q, 1'b0};
	assign diff_l = (two_l >= w_ext) ? (two_l - w_ext) : (w_ext - two_l);
	assign diff_r = (two_r >= w_ext) ? (two_r - w_ext) : (w_ext - two_r);
	assign lane_centred = seen && (diff_l < lim) && (diff_r < lim);

	assign init_over   = elapsed_q > TIMER_BITS'(INIT_HOLD_MS);
	assign done_over   = elapsed_q > TIMER_BITS'(DONE_HOLD_MS);
	assign change_over = CMP_W'(elapsed_q) > CMP_W'(max_change_ms_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_KEEP;
			pending_q <= 1'b0;
			side_q    <= '0;
			elapsed_q <= '0;
		end else if (advance) begin
			mode_q    <= mode_d;
			pending_q <= pending_d;
			side_q    <= side_d;
			elapsed_q <= elapsed_d;
		end
	end

	// Next state: frames step the sequence, ticks advance the timer,
	// requests latch only while keeping, aborts drop everything
	always_comb begin
		mode_d    = mode_q;
		pending_d = pending_q;
		side_d    = side_q;
		elapsed_d = elapsed_q;
		case (func_s1)
			FUNC_FRAME: begin
				case (mode_q)
					MODE_KEEP: begin
						if (pending_q && lane_safe) begin
							pending_d = 1'b0;
							mode_d    = (side_q == SIDE_LEFT) ? MODE_INIT_L : MODE_INIT_R;
							elapsed_d = '0;
						end
					end
					MODE_INIT_L: begin
						if (init_over) begin
							mode_d    = MODE_CHG_L;
							elapsed_d = '0;
						end
					end
					MODE_INIT_R: begin
						if (init_over) begin
							mode_d    = MODE_CHG_R;
							elapsed_d = '0;
						end
					end
					MODE_CHG_L, MODE_CHG_R: begin
						if (lane_centred) begin
							mode_d    = MODE_DONE;
							elapsed_d = '0;
						end else if (change_over) begin
							mode_d    = MODE_KEEP;
							elapsed_d = '0;
						end
					end
					MODE_DONE: begin
						if (done_over) begin
							mode_d    = MODE_KEEP;
							elapsed_d = '0;
						end
					end
					default: ;
				endcase
			end
			FUNC_TICK: begin
				// saturate at all ones
				if (elapsed_q != '1) begin
					elapsed_d = elapsed_q + 1'b1;
				end
			end
			FUNC_REQUEST: begin
				if (mode_q == MODE_KEEP) begin
					pending_d = 1'b1;
					side_d    = dir;
				end
			end
			default: begin
				mode_d    = MODE_KEEP;
				pending_d = 1'b0;
				side_d    = '0;
				elapsed_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {3'b000, pending_d, (mode_d != MODE_KEEP), mode_d};
		end
	end

`ifndef SYNTHESIS
	// A latched request only exists while keeping lane
	a_pending_only_keep: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (mode_q == MODE_KEEP))
		else $error("request pending outside lane keeping");

	// Every state transition restarts the timer
	a_timer_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != $past(mode_q)) |-> (elapsed_q == '0))
		else $error("timer not cleared on transition");

	// The changing flag of a result agrees with its state code
	a_changing_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (data_s2[3] == (data_s2[2:0] != MODE_KEEP)))
		else $error("changing flag disagrees with state code");

	// With the result register empty the input side must never stall
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with empty result register");
`endif

endmodule
